// ----- sv/hkat_pkg.sv -----
`timescale 1ns / 1ps
package hkat_pkg;

	localparam int TABLE_DEPTH   = 6;
	localparam int MODIFIER_BITS = 8;
	localparam logic BIT0        = 1'b1;

	localparam int OP_W       = 2;
	localparam int MOD_FIELD_W = 8;
	localparam int KEY_W      = 16;
	localparam int STAMP_W    = 32;
	localparam int THR_W      = 8;
	localparam int COUNT_FIELD_W = 3;
	localparam int CNT_W      = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	localparam int ADDR_W     = 3;
	localparam int DATA_W     = 32;
	localparam logic REG_FORGET_THRESHOLD = 1'b0;
	localparam logic [THR_W-1:0] THR_RESET = THR_W'(5);

	typedef enum logic [OP_W-1:0] {
		OP_TICK   = 2'd0,
		OP_REPORT = 2'd1,
		OP_READ   = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_TICK_INC,
		ST_TICK_SCAN,
		ST_REP_MODS,
		ST_REP_SCAN,
		ST_REP_PLACE,
		ST_RD,
		ST_CLEAR,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic take;
		logic tick_inc;
		logic tick_step;
		logic tick_finish;
		logic rep_mods;
		logic rep_step;
		logic rep_place;
		logic rd_emit;
		logic clear;
		logic resp_load;
	} cmd_t;

	typedef struct packed {
		logic key_zero;
		logic scan_end;
		logic match;
		logic empty;
		logic out_free;
		logic last_entry;
	} status_t;

endpackage

// ----- sv/hkat_ctrl.sv -----
`timescale 1ns / 1ps
module hkat_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  hkat_pkg::op_t    in_op,
	input  hkat_pkg::status_t st,
	output logic             in_ready,
	output hkat_pkg::cmd_t   cmd
);
	import hkat_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					case (in_op)
						OP_TICK:   state_d = ST_TICK_INC;
						OP_REPORT: state_d = ST_REP_MODS;
						OP_READ:   state_d = ST_RD;
						OP_CLEAR:  state_d = ST_CLEAR;
						default:   state_d = ST_IDLE;
					endcase
				end
			end
			ST_TICK_INC: begin
				cmd.tick_inc = 1'b1;
				state_d = ST_TICK_SCAN;
			end
			ST_TICK_SCAN: begin
				if (st.scan_end) begin
					cmd.tick_finish = 1'b1;
					state_d = ST_RESP;
				end else begin
					cmd.tick_step = 1'b1;
				end
			end
			ST_REP_MODS: begin
				cmd.rep_mods = 1'b1;
				state_d = st.key_zero ? ST_RESP : ST_REP_SCAN;
			end
			ST_REP_SCAN: begin
				if (st.scan_end) begin
					state_d = ST_REP_PLACE;
				end else begin
					cmd.rep_step = 1'b1;
					if (st.match) begin
						state_d = ST_RESP;
					end
				end
			end
			ST_REP_PLACE: begin
				cmd.rep_place = 1'b1;
				state_d = ST_RESP;
			end
			ST_RD: begin
				if (st.empty) begin
					state_d = ST_RESP;
				end else if (st.out_free) begin
					cmd.rd_emit = 1'b1;
					if (st.last_entry) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (st.out_free) begin
					cmd.resp_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

// ----- sv/hkat_dpath.sv -----
`timescale 1ns / 1ps
module hkat_dpath (
	input  logic                              clk,
	input  logic                              arst_n,
	input  hkat_pkg::cmd_t                    cmd,
	output hkat_pkg::status_t                 st,
	input  logic [hkat_pkg::THR_W-1:0]        thr,
	input  logic [hkat_pkg::OP_W-1:0]         op,
	input  logic [hkat_pkg::MOD_FIELD_W-1:0]  modifier_bits,
	input  logic [hkat_pkg::KEY_W-1:0]        key_code,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [hkat_pkg::STAMP_W-1:0]      tick_count,
	output logic [hkat_pkg::MOD_FIELD_W-1:0]  held_modifiers,
	output logic [hkat_pkg::COUNT_FIELD_W-1:0] held_count,
	output logic [hkat_pkg::KEY_W-1:0]        held_key,
	output logic                              key_valid,
	output logic                              last
);
	import hkat_pkg::*;

	function automatic logic expired(input logic [STAMP_W-1:0] stamp,
			input logic [THR_W-1:0] th, input logic [STAMP_W-1:0] now);
		logic [STAMP_W:0] lim;
		lim = {1'b0, stamp} + (STAMP_W+1)'(th);
		return lim <= {1'b0, now};
	endfunction

	// key table: one read port at idx_q, no reset (entries at or above total_q are dead)
	logic [KEY_W-1:0]   key_q    [TABLE_DEPTH];
	logic [STAMP_W-1:0] kstamp_q [TABLE_DEPTH];

	logic [STAMP_W-1:0]       mstamp_q [MODIFIER_BITS];
	logic [MODIFIER_BITS-1:0] mask_q;
	logic [STAMP_W-1:0]       cnt_q;
	logic [CNT_W-1:0]         total_q;
	logic [CNT_W-1:0]         idx_q;
	logic [CNT_W-1:0]         wr_q;
	logic [IDX_W-1:0]         slot_q;
	logic [STAMP_W-1:0]       oldest_q;
	op_t                      op_q;
	logic [MODIFIER_BITS-1:0] mods_q;
	logic [KEY_W-1:0]         code_q;

	logic [KEY_W-1:0]   rd_key;
	logic [STAMP_W-1:0] rd_stamp;
	logic               rd_keep;
	logic [CNT_W-1:0]   idx_nxt;
	logic               full;
	logic               out_free;

	logic [STAMP_W-1:0]       tick_count_q;
	logic [MODIFIER_BITS-1:0] held_mod_q;
	logic [CNT_W-1:0]         held_cnt_q;
	logic [KEY_W-1:0]         held_key_q;
	logic                     key_valid_q;
	logic                     last_q;
	logic                     out_valid_q;

	assign rd_key   = key_q[idx_q[IDX_W-1:0]];
	assign rd_stamp = kstamp_q[idx_q[IDX_W-1:0]];
	assign rd_keep  = !expired(rd_stamp, thr, cnt_q);
	assign idx_nxt  = idx_q + CNT_W'(1);
	assign full     = (total_q == CNT_W'(TABLE_DEPTH));
	assign out_free = !out_valid_q || out_ready;

	assign st.key_zero   = (code_q == '0);
	assign st.scan_end   = (idx_q == total_q);
	assign st.match      = (rd_key == code_q);
	assign st.empty      = (total_q == '0);
	assign st.out_free   = out_free;
	assign st.last_entry = (idx_nxt == total_q);

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			op_q   <= op_t'(op);
			mods_q <= modifier_bits[MODIFIER_BITS-1:0];
			code_q <= key_code;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.tick_step && rd_keep) begin
			key_q[wr_q[IDX_W-1:0]]    <= rd_key;
			kstamp_q[wr_q[IDX_W-1:0]] <= rd_stamp;
		end else if (cmd.rep_step && st.match) begin
			kstamp_q[idx_q[IDX_W-1:0]] <= cnt_q;
		end else if (cmd.rep_place) begin
			if (full) begin
				key_q[slot_q]    <= code_q;
				kstamp_q[slot_q] <= cnt_q;
			end else begin
				key_q[total_q[IDX_W-1:0]]    <= code_q;
				kstamp_q[total_q[IDX_W-1:0]] <= cnt_q;
			end
		end
	end

	// oldest-entry tracker for replacement; first smallest wins
	always_ff @(posedge clk) begin
		if (cmd.rep_step && (idx_q == '0 || rd_stamp < oldest_q)) begin
			oldest_q <= rd_stamp;
			slot_q   <= idx_q[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			total_q <= '0;
			mask_q  <= '0;
			idx_q   <= '0;
			wr_q    <= '0;
			for (int b = 0; b < MODIFIER_BITS; b++) begin
				mstamp_q[b] <= '0;
			end
		end else begin
			if (cmd.take) begin
				idx_q <= '0;
				wr_q  <= '0;
			end
			if (cmd.tick_inc && cnt_q != '1) begin
				cnt_q <= cnt_q + STAMP_W'(1);
			end
			if (cmd.tick_step) begin
				idx_q <= idx_nxt;
				if (rd_keep) begin
					wr_q <= wr_q + CNT_W'(1);
				end
			end
			if (cmd.tick_finish) begin
				total_q <= wr_q;
				for (int b = 0; b < MODIFIER_BITS; b++) begin
					if (mask_q[b] && expired(mstamp_q[b], thr, cnt_q)) begin
						mask_q[b] <= 1'b0;
					end
				end
			end
			if (cmd.rep_mods) begin
				for (int b = 0; b < MODIFIER_BITS; b++) begin
					if (mods_q[b]) begin
						mask_q[b]   <= BIT0;
						mstamp_q[b] <= cnt_q;
					end
				end
			end
			if (cmd.rep_step) begin
				idx_q <= idx_nxt;
			end
			if (cmd.rep_place && !full) begin
				total_q <= total_q + CNT_W'(1);
			end
			if (cmd.rd_emit) begin
				idx_q <= idx_nxt;
			end
			if (cmd.clear) begin
				total_q <= '0;
				mask_q  <= '0;
				for (int b = 0; b < MODIFIER_BITS; b++) begin
					mstamp_q[b] <= '0;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.rd_emit || cmd.resp_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_emit) begin
			tick_count_q <= '0;
			held_mod_q   <= mask_q;
			held_cnt_q   <= total_q;
			held_key_q   <= rd_key;
			key_valid_q  <= 1'b1;
			last_q       <= st.last_entry;
		end else if (cmd.resp_load) begin
			tick_count_q <= (op_q == OP_TICK) ? cnt_q : '0;
			held_mod_q   <= mask_q;
			held_cnt_q   <= total_q;
			held_key_q   <= '0;
			key_valid_q  <= 1'b0;
			last_q       <= 1'b1;
		end
	end

	assign out_valid      = out_valid_q;
	assign tick_count     = tick_count_q;
	assign held_modifiers = MOD_FIELD_W'(held_mod_q);
	assign held_count     = COUNT_FIELD_W'(held_cnt_q);
	assign held_key       = held_key_q;
	assign key_valid      = key_valid_q;
	assign last           = last_q;

endmodule

// ----- sv/held_key_aging_table_core.sv -----
`timescale 1ns / 1ps
// channel   signals                                              direction
// in        in_valid/in_ready, op, modifier_bits, key_code        in
// out       out_valid/out_ready, tick_count, held_modifiers,      out
//           held_count, held_key, key_valid, last
// cfg       psel, penable, pwrite, paddr, pwdata, prdata, pready  APB slave
//
// One item at a time; a new beat is taken only in the idle state.
// Tick: increments the stamp, then one table entry per cycle through the single read port.
// Report: a zero key updates the modifiers only; a nonzero key adds the key match/oldest scan.
// Read-out: one result per cycle per held key. Output stalls hold the
// controller in its emit state. Reset empties the table and mask; threshold returns to 5.
module held_key_aging_table_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [hkat_pkg::OP_W-1:0]           op,
	input  logic [hkat_pkg::MOD_FIELD_W-1:0]    modifier_bits,
	input  logic [hkat_pkg::KEY_W-1:0]          key_code,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [hkat_pkg::STAMP_W-1:0]        tick_count,
	output logic [hkat_pkg::MOD_FIELD_W-1:0]    held_modifiers,
	output logic [hkat_pkg::COUNT_FIELD_W-1:0]  held_count,
	output logic [hkat_pkg::KEY_W-1:0]          held_key,
	output logic                                key_valid,
	output logic                                last,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [hkat_pkg::ADDR_W-1:0]         paddr,
	input  logic [hkat_pkg::DATA_W-1:0]         pwdata,
	output logic [hkat_pkg::DATA_W-1:0]         prdata,
	output logic                                pready
);
	import hkat_pkg::*;

	cmd_t             cmd;
	status_t          st;
	logic [THR_W-1:0] thr_q;
	logic             thr_sel;

	assign pready  = 1'b1;
	assign thr_sel = (paddr[ADDR_W-1] == REG_FORGET_THRESHOLD);
	assign prdata  = thr_sel ? DATA_W'(thr_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (psel && penable && pwrite && thr_sel) begin
			thr_q <= pwdata[THR_W-1:0];
		end
	end

	hkat_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_op    (op_t'(op)),
		.st       (st),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	hkat_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.thr            (thr_q),
		.op             (op),
		.modifier_bits  (modifier_bits),
		.key_code       (key_code),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.tick_count     (tick_count),
		.held_modifiers (held_modifiers),
		.held_count     (held_count),
		.held_key       (held_key),
		.key_valid      (key_valid),
		.last           (last)
	);

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
	import hkat_pkg::*;

	localparam int KEY_POOL_N  = 9;
	localparam int SETTLE_CYC  = 16;
	localparam int BURST_CYC   = 300;
	localparam int MAX_PRINTS  = 60;

	typedef struct {
		op_t                     op;
		logic [MOD_FIELD_W-1:0]  mods;
		logic [KEY_W-1:0]        key;
	} key_event_t;

	typedef struct packed {
		logic [STAMP_W-1:0]       tick_count;
		logic [MOD_FIELD_W-1:0]   mods;
		logic [COUNT_FIELD_W-1:0] count;
		logic [KEY_W-1:0]         key;
		logic                     valid;
		logic                     last;
	} table_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [OP_W-1:0] op = '0;
	logic [MOD_FIELD_W-1:0] modifier_bits = '0;
	logic [KEY_W-1:0] key_code = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [STAMP_W-1:0] tick_count;
	logic [MOD_FIELD_W-1:0] held_modifiers;
	logic [COUNT_FIELD_W-1:0] held_count;
	logic [KEY_W-1:0] held_key;
	logic key_valid;
	logic last;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	held_key_aging_table_core u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .modifier_bits(modifier_bits), .key_code(key_code),
		.out_valid(out_valid), .out_ready(out_ready),
		.tick_count(tick_count), .held_modifiers(held_modifiers),
		.held_count(held_count), .held_key(held_key),
		.key_valid(key_valid), .last(last),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	key_event_t    key_event_q[$];
	table_result_t expected_table_q[$];
	int            mismatches = 0;
	int            tx_idle_pct = 0;
	int            rx_stall_pct = 0;
	int            burst_left = 0;
	logic          beat_taken = 1'b0;
	logic [KEY_W-1:0] key_pool[KEY_POOL_N];

	// shadow of the aging table
	logic [STAMP_W-1:0]       sim_ticks = '0;
	logic [MODIFIER_BITS-1:0] sim_mods = '0;
	logic [STAMP_W-1:0]       sim_mod_stamp[MODIFIER_BITS];
	logic [KEY_W-1:0]         sim_keys[TABLE_DEPTH];
	logic [STAMP_W-1:0]       sim_key_stamp[TABLE_DEPTH];
	int                       sim_count = 0;
	logic [THR_W-1:0]         sim_threshold = THR_RESET;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("[FAIL] regression broken");
		$finish;
	end

	task automatic flag_mismatch(input string what, input logic [STAMP_W-1:0] got,
			input logic [STAMP_W-1:0] want);
		mismatches++;
		if (mismatches <= MAX_PRINTS)
			$display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
	endtask

	// no wrap: stamp + threshold formed at 33 bits
	function automatic logic is_stale(input logic [STAMP_W-1:0] stamp);
		logic [STAMP_W:0] sum;
		sum = {1'b0, stamp} + {{(STAMP_W+1-THR_W){1'b0}}, sim_threshold};
		return sum <= {1'b0, sim_ticks};
	endfunction

	task automatic queue_result(input logic [STAMP_W-1:0] tc, input logic [KEY_W-1:0] key,
			input logic valid, input logic fin);
		table_result_t r;
		r.tick_count = tc;
		r.mods = MOD_FIELD_W'(sim_mods);
		r.count = COUNT_FIELD_W'(sim_count);
		r.key = key;
		r.valid = valid;
		r.last = fin;
		expected_table_q.push_back(r);
	endtask

	task automatic wipe_table();
		sim_count = 0;
		sim_mods = '0;
		for (int i = 0; i < MODIFIER_BITS; i++) sim_mod_stamp[i] = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			sim_keys[i] = '0;
			sim_key_stamp[i] = '0;
		end
	endtask

	task automatic advance_table(input key_event_t ev);
		int i;
		int slot;
		logic found;
		logic [STAMP_W-1:0] oldest;
		case (ev.op)
			OP_TICK: begin
				if (sim_ticks != '1) sim_ticks++;
				// re-examine the slot after a removal, the shifted entry may be stale too
				i = 0;
				while (i < sim_count) begin
					if (is_stale(sim_key_stamp[i])) begin
						for (int j = i; j + 1 < sim_count; j++) begin
							sim_keys[j] = sim_keys[j + 1];
							sim_key_stamp[j] = sim_key_stamp[j + 1];
						end
						sim_count--;
					end else begin
						i++;
					end
				end
				for (int b = 0; b < MODIFIER_BITS; b++)
					if (sim_mods[b] && is_stale(sim_mod_stamp[b])) sim_mods[b] = 1'b0;
				queue_result(sim_ticks, '0, 1'b0, 1'b1);
			end
			OP_REPORT: begin
				for (int b = 0; b < MODIFIER_BITS; b++) begin
					if (ev.mods[b]) begin
						sim_mods[b] = 1'b1;
						sim_mod_stamp[b] = sim_ticks;
					end
				end
				if (ev.key != '0) begin
					found = 1'b0;
					for (i = 0; i < sim_count; i++) begin
						if (!found && sim_keys[i] == ev.key) begin
							sim_key_stamp[i] = sim_ticks;
							found = 1'b1;
						end
					end
					if (!found && sim_count >= TABLE_DEPTH) begin
						// oldest stamp goes, first one wins a tie
						slot = 0;
						oldest = sim_key_stamp[0];
						for (i = 1; i < TABLE_DEPTH; i++) begin
							if (oldest > sim_key_stamp[i]) begin
								oldest = sim_key_stamp[i];
								slot = i;
							end
						end
						sim_keys[slot] = ev.key;
						sim_key_stamp[slot] = sim_ticks;
					end else if (!found) begin
						sim_keys[sim_count] = ev.key;
						sim_key_stamp[sim_count] = sim_ticks;
						sim_count++;
					end
				end
				queue_result('0, '0, 1'b0, 1'b1);
			end
			OP_READ: begin
				if (sim_count == 0)
					queue_result('0, '0, 1'b0, 1'b1);
				else
					for (i = 0; i < sim_count; i++)
						queue_result('0, sim_keys[i], 1'b1, i + 1 == sim_count);
			end
			default: begin
				wipe_table();
				queue_result('0, '0, 1'b0, 1'b1);
			end
		endcase
	endtask

	task automatic queue_event(input op_t o, input logic [MOD_FIELD_W-1:0] m,
			input logic [KEY_W-1:0] k);
		key_event_t ev;
		ev.op = o;
		ev.mods = m;
		ev.key = k;
		key_event_q.push_back(ev);
	endtask

	function automatic key_event_t random_event();
		key_event_t ev;
		int roll;
		int pick;
		roll = $urandom_range(99);
		// fields the op ignores carry noise
		ev.mods = MOD_FIELD_W'($urandom);
		ev.key = KEY_W'($urandom);
		if (roll < 50) begin
			ev.op = OP_REPORT;
			pick = $urandom_range(99);
			if (pick < 12) ev.key = '0;
			else if (pick < 80) ev.key = key_pool[$urandom_range(KEY_POOL_N - 1)];
			else ev.key = KEY_W'($urandom_range(65535, 1));
			case ($urandom_range(3))
				0: ev.mods = '0;
				1: ev.mods = MOD_FIELD_W'(1) << $urandom_range(MOD_FIELD_W - 1);
				default: ev.mods = MOD_FIELD_W'($urandom);
			endcase
		end else if (roll < 75) begin
			ev.op = OP_TICK;
		end else if (roll < 93) begin
			ev.op = OP_READ;
		end else begin
			ev.op = OP_CLEAR;
		end
		return ev;
	endfunction

	// input driver: one beat held until taken
	always @(negedge clk) begin : drv
		key_event_t ev;
		if (!in_valid || beat_taken) begin
			if (arst_n && key_event_q.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
				ev = key_event_q.pop_front();
				in_valid <= 1'b1;
				op <= ev.op;
				modifier_bits <= ev.mods;
				key_code <= ev.key;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side backpressure, with a long hold-off when burst_left is loaded
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (burst_left > 0) begin
			burst_left = burst_left - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin : mon
		key_event_t ev;
		table_result_t want;
		if (arst_n) begin
			beat_taken <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				ev.op = op_t'(op);
				ev.mods = modifier_bits;
				ev.key = key_code;
				advance_table(ev);
			end
			if (out_valid && out_ready) begin
				if (expected_table_q.size() == 0) begin
					flag_mismatch("result beat with nothing expected", {29'b0, held_count},
						'0);
				end else begin
					want = expected_table_q.pop_front();
					if (tick_count !== want.tick_count)
						flag_mismatch("tick_count", tick_count, want.tick_count);
					if (held_modifiers !== want.mods)
						flag_mismatch("held_modifiers", STAMP_W'(held_modifiers),
							STAMP_W'(want.mods));
					if (held_count !== want.count)
						flag_mismatch("held_count", STAMP_W'(held_count),
							STAMP_W'(want.count));
					if (held_key !== want.key)
						flag_mismatch("held_key", STAMP_W'(held_key), STAMP_W'(want.key));
					if (key_valid !== want.valid)
						flag_mismatch("key_valid", STAMP_W'(key_valid),
							STAMP_W'(want.valid));
					if (last !== want.last)
						flag_mismatch("last", STAMP_W'(last), STAMP_W'(want.last));
				end
			end
		end else begin
			beat_taken <= 1'b0;
		end
	end

	task automatic wait_drained();
		@(posedge clk);
		while (key_event_q.size() != 0 || in_valid || expected_table_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic check_threshold();
		logic [DATA_W-1:0] rd;
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= ADDR_W'(4 * REG_FORGET_THRESHOLD);
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		if (rd[THR_W-1:0] !== sim_threshold)
			flag_mismatch("forget_threshold readback", {24'b0, rd[THR_W-1:0]},
				{24'b0, sim_threshold});
	endtask

	task automatic write_threshold(input logic [THR_W-1:0] thr);
		@(negedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'(4 * REG_FORGET_THRESHOLD);
		pwdata <= DATA_W'(thr);
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sim_threshold = thr;
		check_threshold();
	endtask

	task automatic run_phase(input logic [THR_W-1:0] thr, input int tx, input int rx,
			input int n, input logic burst, input logic split);
		write_threshold(thr);
		key_pool[0] = 16'hFFFF;
		key_pool[1] = 16'h0001;
		for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = KEY_W'($urandom_range(65535, 1));
		@(posedge clk);
		tx_idle_pct = tx;
		rx_stall_pct = rx;
		for (int i = 0; i < n; i++) begin
			key_event_q.push_back(random_event());
			// sender waits for every result before the second half
			if (split && i == n / 2) wait_drained();
		end
		if (burst) burst_left = BURST_CYC;
		wait_drained();
	endtask

	initial begin
		wipe_table();
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (4) @(posedge clk);
		check_threshold();

		// directed pass at the reset threshold
		queue_event(OP_READ, '0, '0);
		queue_event(OP_REPORT, 8'hFF, '0);
		queue_event(OP_REPORT, 8'h00, 16'hFFFF);
		for (int k = 1; k <= 5; k++) queue_event(OP_REPORT, 8'h00, KEY_W'(k));
		queue_event(OP_READ, '0, '0);
		queue_event(OP_REPORT, 8'h01, 16'h8000);
		queue_event(OP_REPORT, 8'h00, 16'h0003);
		queue_event(OP_TICK, '0, '0);
		queue_event(OP_TICK, '0, '0);
		queue_event(OP_REPORT, 8'h80, 16'h0002);
		queue_event(OP_REPORT, 8'h00, 16'h1234);
		repeat (3) queue_event(OP_TICK, '0, '0);
		queue_event(OP_READ, '0, '0);
		repeat (2) queue_event(OP_TICK, '0, '0);
		queue_event(OP_REPORT, 8'h5A, 16'hABCD);
		queue_event(OP_CLEAR, 8'hA5, 16'h5555);
		queue_event(OP_READ, 8'hFF, 16'hFFFF);
		wait_drained();

		run_phase(8'd255, 0, 0, 45, 1'b0, 1'b0);
		run_phase(8'd3, 45, 0, 45, 1'b0, 1'b0);
		run_phase(8'd1, 0, 45, 45, 1'b1, 1'b0);
		run_phase(THR_W'($urandom_range(20, 2)), 33, 33, 45, 1'b0, 1'b1);
		run_phase(8'd0, 0, 0, 50, 1'b0, 1'b0);

		repeat (20) @(posedge clk);
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
